>>> rtl/eac_pkg.sv
// Package for the Euler angle to quaternion unit: widths, constants and types.
// Holds the CORDIC arctangent table. Depends on nothing.
package eac_pkg;

	localparam int ANGLE_WIDTH  = 16;
	localparam int QUAT_WIDTH   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int FRAC         = 30;
	localparam int CW           = 34;  // CORDIC datapath width
	localparam int TW           = 32;  // trig value width after the CORDIC
	localparam int IDX_W        = 5;
	localparam int LANES        = 3;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] HALF_PI     = 34'sd1686629713;
	localparam logic signed [CW-1:0] PI_Q        = 34'sd3373259426;

	// Lane codes: roll, pitch, yaw.
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_Z = 2;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} lane_t;

	typedef struct packed {
		logic                   valid;
		logic [LANES-1:0]       neg;
		lane_t [LANES-1:0]      lane;
	} cell_word_t;

	// Arctangent of 2^-i in Q30, rounded down.
	function automatic logic signed [CW-1:0] atan_at(input logic [IDX_W-1:0] i);
		logic signed [CW-1:0] r;
		begin
			unique case (i)
				5'd0:  r = 34'sd843314856;
				5'd1:  r = 34'sd497837829;
				5'd2:  r = 34'sd263043836;
				5'd3:  r = 34'sd133525158;
				5'd4:  r = 34'sd67021686;
				5'd5:  r = 34'sd33543515;
				5'd6:  r = 34'sd16775850;
				5'd7:  r = 34'sd8388437;
				5'd8:  r = 34'sd4194282;
				5'd9:  r = 34'sd2097149;
				5'd10: r = 34'sd1048575;
				5'd11: r = 34'sd524287;
				5'd12: r = 34'sd262143;
				5'd13: r = 34'sd131071;
				5'd14: r = 34'sd65535;
				5'd15: r = 34'sd32767;
				5'd16: r = 34'sd16383;
				5'd17: r = 34'sd8191;
				5'd18: r = 34'sd4095;
				5'd19: r = 34'sd2047;
				5'd20: r = 34'sd1023;
				5'd21: r = 34'sd511;
				5'd22: r = 34'sd255;
				5'd23: r = 34'sd127;
				5'd24: r = 34'sd63;
				5'd25: r = 34'sd31;
				5'd26: r = 34'sd15;
				5'd27: r = 34'sd7;
				5'd28: r = 34'sd3;
				5'd29: r = 34'sd1;
				default: r = 34'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

>>> rtl/euler_angles_to_quaternion_unit.sv
// Top level of the ZYX Euler angle to unit quaternion converter.
// Depends on eac_pkg, eac_cordic_cell and eac_combine.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | roll_angle, pitch_angle, yaw_angle
//  output  | out_valid | out_stall | quat_x, quat_y, quat_z, quat_w
//
// One word is taken per cycle while no finished word stalls at the output; the path from input to
// output is one fold stage, sixteen CORDIC cells and five product and rounding stages.
// Reset clears only the valid bits of the pipeline.
// A stalled output word freezes the whole pipeline; in_stall then rises, and
// while the output holds no word the pipeline keeps moving under any stall.
module euler_angles_to_quaternion_unit import eac_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
	input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
	input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [QUAT_WIDTH-1:0]  quat_x,
	output logic signed [QUAT_WIDTH-1:0]  quat_y,
	output logic signed [QUAT_WIDTH-1:0]  quat_z,
	output logic signed [QUAT_WIDTH-1:0]  quat_w
);

	logic                  en;
	logic signed [CW-1:0]  h [LANES];
	logic signed [CW-1:0]  hf [LANES];
	logic [LANES-1:0]      neg;
	cell_word_t            chain [CORDIC_STEPS+1];

	// Pipeline moves unless a finished word waits at the output.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Half angle in Q30 and quadrant fold.
	assign h[LANE_X] = {{(CW-32){roll_angle[ANGLE_WIDTH-1]}},  roll_angle,
		{(32-ANGLE_WIDTH){1'b0}}};
	assign h[LANE_Y] = {{(CW-32){pitch_angle[ANGLE_WIDTH-1]}}, pitch_angle,
		{(32-ANGLE_WIDTH){1'b0}}};
	assign h[LANE_Z] = {{(CW-32){yaw_angle[ANGLE_WIDTH-1]}},   yaw_angle,
		{(32-ANGLE_WIDTH){1'b0}}};

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			priority if (h[l] > HALF_PI) begin
				hf[l]  = h[l] - PI_Q;
				neg[l] = 1'b1;
			end else if (h[l] < -HALF_PI) begin
				hf[l]  = h[l] + PI_Q;
				neg[l] = 1'b1;
			end else begin
				hf[l]  = h[l];
				neg[l] = 1'b0;
			end
		end
	end

	// Fold stage register feeding the first cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0].valid <= 1'b0;
		end else if (en) begin
			chain[0].valid <= in_valid;
			chain[0].neg   <= neg;
			for (int l = 0; l < LANES; l++) begin
				chain[0].lane[l].x <= CORDIC_GAIN;
				chain[0].lane[l].y <= '0;
				chain[0].lane[l].z <= hf[l];
			end
		end
	end

	// Row of CORDIC cells, one micro-rotation each.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		eac_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.idx    (IDX_W'(i)),
			.d_in   (chain[i]),
			.d_out  (chain[i+1])
		);
	end

	eac_combine u_combine (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.d_in    (chain[CORDIC_STEPS]),
		.valid_q (out_valid),
		.qx_q    (quat_x),
		.qy_q    (quat_y),
		.qz_q    (quat_z),
		.qw_q    (quat_w)
	);

	// A waiting word is never dropped while the output stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(quat_w))
		else $error("output word lost under stall");

	// A frozen pipeline keeps its first cell unchanged.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[1].valid))
		else $error("cell moved while frozen");

	// The w and x components stay within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_w <= 16'sd16384) && (quat_w >= -16'sd16384) &&
			(quat_x <= 16'sd16384) && (quat_x >= -16'sd16384))
		else $error("component out of range");

endmodule

>>> rtl/eac_cordic_cell.sv
// One CORDIC rotation cell: a micro-rotation for all three angle lanes.
// Depends on eac_pkg.
module eac_cordic_cell import eac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] idx,
	input  cell_word_t       d_in,
	output cell_word_t       d_out
);

	cell_word_t           nxt;
	logic signed [CW-1:0] atan_c;

	assign atan_c = atan_at(idx);

	// Rotate each lane towards zero residual angle.
	always_comb begin
		nxt       = d_in;
		for (int l = 0; l < LANES; l++) begin
			if (!d_in.lane[l].z[CW-1]) begin
				nxt.lane[l].x = d_in.lane[l].x - (d_in.lane[l].y >>> idx);
				nxt.lane[l].y = d_in.lane[l].y + (d_in.lane[l].x >>> idx);
				nxt.lane[l].z = d_in.lane[l].z - atan_c;
			end else begin
				nxt.lane[l].x = d_in.lane[l].x + (d_in.lane[l].y >>> idx);
				nxt.lane[l].y = d_in.lane[l].y - (d_in.lane[l].x >>> idx);
				nxt.lane[l].z = d_in.lane[l].z + atan_c;
			end
		end
	end

	// Only the valid bit is reset; the data word follows it when enabled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out.valid <= 1'b0;
		end else if (en) begin
			d_out <= nxt;
		end
	end

endmodule

>>> rtl/eac_combine.sv
// Hamilton product of the three axis quaternions, rounding and saturation.
// Depends on eac_pkg; fed by the last CORDIC cell.
module eac_combine import eac_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  cell_word_t                   d_in,
	output logic                         valid_q,
	output logic signed [QUAT_WIDTH-1:0] qx_q,
	output logic signed [QUAT_WIDTH-1:0] qy_q,
	output logic signed [QUAT_WIDTH-1:0] qz_q,
	output logic signed [QUAT_WIDTH-1:0] qw_q
);

	localparam int SH  = 2 * FRAC + 2 - QUAT_WIDTH;
	localparam int PW  = 2 * TW;
	localparam int SW  = PW + 2;
	localparam int RW  = SW - SH;
	localparam logic signed [RW-1:0] LIM = RW'(1) <<< (QUAT_WIDTH - 2);

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic signed [TW-1:0]  s_s1 [LANES], c_s1 [LANES];
	logic signed [TW-1:0]  sx_s2, cx_s2;
	logic signed [TW-1:0]  czcy_s2, szsy_s2, czsy_s2, szcy_s2;
	logic signed [PW-1:0]  pr_s3 [8];
	logic signed [SW-1:0]  sum_s4 [4];
	logic signed [PW-1:0]  czcy, szsy, czsy, szcy;
	logic signed [RW-1:0]  rnd [4];
	logic signed [QUAT_WIDTH-1:0] sat [4];

	// Valid bits along the product pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= d_in.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= v_s4;
		end
	end

	// Apply the quadrant fold sign and narrow to trig width.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				c_s1[l] <= d_in.neg[l] ? TW'(-d_in.lane[l].x) : TW'(d_in.lane[l].x);
				s_s1[l] <= d_in.neg[l] ? TW'(-d_in.lane[l].y) : TW'(d_in.lane[l].y);
			end
		end
	end

	// Pair products of yaw and pitch, rounded back to Q30.
	assign czcy = c_s1[LANE_Z] * c_s1[LANE_Y];
	assign szsy = s_s1[LANE_Z] * s_s1[LANE_Y];
	assign czsy = c_s1[LANE_Z] * s_s1[LANE_Y];
	assign szcy = s_s1[LANE_Z] * c_s1[LANE_Y];

	always_ff @(posedge clk) begin
		if (en) begin
			czcy_s2 <= TW'((czcy + (PW'(1) <<< (FRAC - 1))) >>> FRAC);
			szsy_s2 <= TW'((szsy + (PW'(1) <<< (FRAC - 1))) >>> FRAC);
			czsy_s2 <= TW'((czsy + (PW'(1) <<< (FRAC - 1))) >>> FRAC);
			szcy_s2 <= TW'((szcy + (PW'(1) <<< (FRAC - 1))) >>> FRAC);
			sx_s2   <= s_s1[LANE_X];
			cx_s2   <= c_s1[LANE_X];
		end
	end

	// Full Q60 products with the roll terms.
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s3[0] <= czcy_s2 * sx_s2;
			pr_s3[1] <= szsy_s2 * cx_s2;
			pr_s3[2] <= czsy_s2 * cx_s2;
			pr_s3[3] <= szcy_s2 * sx_s2;
			pr_s3[4] <= szcy_s2 * cx_s2;
			pr_s3[5] <= czsy_s2 * sx_s2;
			pr_s3[6] <= czcy_s2 * cx_s2;
			pr_s3[7] <= szsy_s2 * sx_s2;
		end
	end

	// Exact component sums.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4[0] <= SW'(pr_s3[0]) - SW'(pr_s3[1]);
			sum_s4[1] <= SW'(pr_s3[2]) + SW'(pr_s3[3]);
			sum_s4[2] <= SW'(pr_s3[4]) - SW'(pr_s3[5]);
			sum_s4[3] <= SW'(pr_s3[6]) + SW'(pr_s3[7]);
		end
	end

	// Round half up to output precision, then clamp to plus or minus one.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rnd[k] = RW'((sum_s4[k] + (SW'(1) <<< (SH - 1))) >>> SH);
			if (rnd[k] > LIM) begin
				sat[k] = QUAT_WIDTH'(LIM);
			end else if (rnd[k] < -LIM) begin
				sat[k] = QUAT_WIDTH'(-LIM);
			end else begin
				sat[k] = QUAT_WIDTH'(rnd[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_q <= sat[0];
			qy_q <= sat[1];
			qz_q <= sat[2];
			qw_q <= sat[3];
		end
	end

endmodule

>>> bench/testbench.sv
// Self-checking bench for the ZYX Euler angle to quaternion converter.
// Depends on eac_pkg and euler_angles_to_quaternion_unit; every word is checked
// against a bit-exact CORDIC and product predictor kept here.
module testbench;
	import eac_pkg::*;

	typedef struct {
		logic signed [QUAT_WIDTH-1:0] x;
		logic signed [QUAT_WIDTH-1:0] y;
		logic signed [QUAT_WIDTH-1:0] z;
		logic signed [QUAT_WIDTH-1:0] w;
	} quat_t;

	typedef struct {
		logic signed [ANGLE_WIDTH-1:0] roll;
		logic signed [ANGLE_WIDTH-1:0] pitch;
		logic signed [ANGLE_WIDTH-1:0] yaw;
	} euler_t;

	localparam int RANDOM_WORDS = 830;
	localparam int HOLD_CYCLES  = 90;
	localparam int DRAIN_CYCLES = 40;

	// Arctangent of 2^-i in Q30, rounded down.
	localparam longint ATAN_Q30 [32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 7, 3, 1, 0, 0
	};
	localparam longint GAIN_Q30    = 652032874;
	localparam longint HALFPI_Q30  = 1686629713;
	localparam longint PI_Q30      = 64'sd3373259426;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [ANGLE_WIDTH-1:0] roll_angle;
	logic signed [ANGLE_WIDTH-1:0] pitch_angle;
	logic signed [ANGLE_WIDTH-1:0] yaw_angle;
	logic out_valid;
	logic out_stall;
	logic signed [QUAT_WIDTH-1:0] quat_x;
	logic signed [QUAT_WIDTH-1:0] quat_y;
	logic signed [QUAT_WIDTH-1:0] quat_z;
	logic signed [QUAT_WIDTH-1:0] quat_w;

	quat_t  pending_quats[$];
	int     error_count;
	int     words_taken;
	int     words_checked;
	int     saturated_seen;
	bit     hold_done;
	bit     stimulus_done;

	euler_angles_to_quaternion_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.roll_angle (roll_angle),
		.pitch_angle(pitch_angle),
		.yaw_angle  (yaw_angle),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.quat_w     (quat_w)
	);

	// Clock with a period of four units.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Sine and cosine of half an angle, both Q30, via a folded rotation CORDIC.
	task automatic half_sin_cos(input logic signed [ANGLE_WIDTH-1:0] angle,
			output longint s, output longint c);
		longint px;
		longint py;
		longint pz;
		longint nx;
		bit     flip;
		begin
			pz = longint'(angle) * (longint'(1) << (32 - ANGLE_WIDTH));
			px = GAIN_Q30;
			py = 0;
			flip = 1'b0;
			if (pz > HALFPI_Q30) begin
				pz = pz - PI_Q30;
				flip = 1'b1;
			end else if (pz < -HALFPI_Q30) begin
				pz = pz + PI_Q30;
				flip = 1'b1;
			end
			for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
				if (pz >= 0) begin
					nx = px - (py >>> i);
					py = py + (px >>> i);
					pz = pz - ATAN_Q30[i];
				end else begin
					nx = px + (py >>> i);
					py = py - (px >>> i);
					pz = pz + ATAN_Q30[i];
				end
				px = nx;
			end
			if (flip) begin
				px = -px;
				py = -py;
			end
			s = py;
			c = px;
		end
	endtask

	// Rounded Q30 product of two factors, then times a third to give Q60.
	function automatic longint triple_product(longint a, longint b, longint c);
		longint ab;
		begin
			ab = (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
			return ab * c;
		end
	endfunction

	// Round a Q60 sum to Q1.14, ties upwards, and clamp to plus or minus one.
	function automatic logic signed [QUAT_WIDTH-1:0] round_clamp(longint v);
		longint r;
		longint lim;
		begin
			lim = longint'(1) << (QUAT_WIDTH - 2);
			r = (v + (longint'(1) << (62 - QUAT_WIDTH - 1))) >>> (62 - QUAT_WIDTH);
			if (r > lim)
				r = lim;
			if (r < -lim)
				r = -lim;
			return r[QUAT_WIDTH-1:0];
		end
	endfunction

	// Quaternion qz * qy * qx for one set of Euler angles.
	task automatic predict_quat(input euler_t e, output quat_t q);
		longint sx, cx, sy, cy, sz, cz;
		begin
			half_sin_cos(e.roll, sx, cx);
			half_sin_cos(e.pitch, sy, cy);
			half_sin_cos(e.yaw, sz, cz);
			q.x = round_clamp(triple_product(cz, cy, sx) - triple_product(sz, sy, cx));
			q.y = round_clamp(triple_product(cz, sy, cx) + triple_product(sz, cy, sx));
			q.z = round_clamp(triple_product(sz, cy, cx) - triple_product(cz, sy, sx));
			q.w = round_clamp(triple_product(cz, cy, cx) + triple_product(sz, sy, sx));
		end
	endtask

	// Predict each word as the converter takes it.
	always @(posedge clk) begin
		euler_t e;
		quat_t  q;
		if (arst_n && in_valid && !in_stall) begin
			e.roll = roll_angle;
			e.pitch = pitch_angle;
			e.yaw = yaw_angle;
			predict_quat(e, q);
			pending_quats.push_back(q);
			words_taken++;
		end
	end

	// Compare each delivered word with the oldest prediction.
	always @(posedge clk) begin
		quat_t q;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_quats.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d z=%0d w=%0d",
					$time, quat_x, quat_y, quat_z, quat_w);
				error_count++;
			end else begin
				q = pending_quats.pop_front();
				if (quat_x !== q.x) begin
					$display("%0t: quat_x expected %0d actual %0d", $time, q.x, quat_x);
					error_count++;
				end
				if (quat_y !== q.y) begin
					$display("%0t: quat_y expected %0d actual %0d", $time, q.y, quat_y);
					error_count++;
				end
				if (quat_z !== q.z) begin
					$display("%0t: quat_z expected %0d actual %0d", $time, q.z, quat_z);
					error_count++;
				end
				if (quat_w !== q.w) begin
					$display("%0t: quat_w expected %0d actual %0d", $time, q.w, quat_w);
					error_count++;
				end
				if (q.w == 16384 || q.w == -16384)
					saturated_seen++;
				words_checked++;
			end
		end
	end

	// Receiver stall: random runs of differing density and one long hold-off.
	initial begin
		int run_len;
		int density;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && words_taken > 300) begin
				hold_done = 1'b1;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
			end
			run_len = $urandom_range(5, 60);
			density = $urandom_range(0, 3) * 25;
			for (int i = 0; i < run_len; i++) begin
				@(posedge clk);
				out_stall <= ($urandom_range(0, 99) < density);
			end
		end
	end

	// Present one word and hold it until it is taken.
	task automatic send_euler(input euler_t e);
		begin
			in_valid <= 1'b1;
			roll_angle <= e.roll;
			pitch_angle <= e.pitch;
			yaw_angle <= e.yaw;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
		end
	endtask

	// Random angle, mostly within plus or minus pi, sometimes the full field.
	function automatic logic signed [ANGLE_WIDTH-1:0] random_angle();
		int pick;
		begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				return $urandom_range(0, 2 * 25736) - 25736;
			else if (pick < 8)
				return $urandom();
			else
				return $urandom_range(0, 1) ? $urandom_range(25726, 25746)
					: -$urandom_range(25726, 25746);
		end
	endfunction

	// Sender: directed table, then random words in bursts with gaps.
	initial begin
		euler_t directed [] = '{
			'{16'sd0, 16'sd0, 16'sd0},
			'{16'sd25736, 16'sd0, 16'sd0},
			'{16'sd0, 16'sd25736, 16'sd0},
			'{16'sd0, 16'sd0, 16'sd25736},
			'{-16'sd25736, -16'sd25736, -16'sd25736},
			'{16'sd25736, 16'sd25736, 16'sd25736},
			'{16'sd25737, -16'sd25737, 16'sd25735},
			'{16'sd32767, 16'sd32767, 16'sd32767},
			'{-16'sd32768, -16'sd32768, -16'sd32768},
			'{16'sd32767, -16'sd32768, 16'sd0},
			'{16'sd1, -16'sd1, 16'sd1},
			'{16'sd12868, 16'sd12868, 16'sd12868},
			'{-16'sd12868, 16'sd12868, -16'sd12868},
			'{16'sd6434, -16'sd3217, 16'sd19302},
			'{16'sd0, 16'sd12868, 16'sd0},
			'{-16'sd21846, 16'sd5461, 16'sd30000}
		};
		euler_t e;
		int burst;
		int gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		roll_angle = '0;
		pitch_angle = '0;
		yaw_angle = '0;
		error_count = 0;
		words_taken = 0;
		words_checked = 0;
		saturated_seen = 0;
		stimulus_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_euler(directed[i]);
		in_valid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < RANDOM_WORDS; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++) begin
				e.roll = random_angle();
				e.pitch = random_angle();
				e.yaw = random_angle();
				send_euler(e);
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Drain and report.
	initial begin
		wait (stimulus_done);
		while (pending_quats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d of %0d words, %0d with w clamped to plus or minus one.",
			words_checked, words_taken, saturated_seen);
		if (error_count == 0 && pending_quats.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#800000;
		$display("Run timed out with %0d words outstanding.", pending_quats.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/eac_pkg.sv
rtl/eac_cordic_cell.sv
rtl/eac_combine.sv
rtl/euler_angles_to_quaternion_unit.sv
bench/testbench.sv
